@@ rtl/kpcalc_pkg.sv @@
package kpcalc_pkg;

   // operand width; the block emits the low 32 bits of every result
   localparam int OPW = 32;
   localparam int CW  = $clog2(OPW);
   localparam int RESULT_W = 32;

   // keypad codes
   localparam logic [7:0] KEY_NONE  = 8'h00;
   localparam logic [7:0] KEY_PLUS  = 8'h2B;
   localparam logic [7:0] KEY_MINUS = 8'h2D;
   localparam logic [7:0] KEY_TIMES = 8'h2A;
   localparam logic [7:0] KEY_DIV   = 8'h2F;
   localparam logic [7:0] KEY_EQ    = 8'h3D;
   localparam logic [7:0] KEY_ZERO  = 8'h30;
   localparam logic [7:0] KEY_NINE  = 8'h39;

   // serial unit operations
   localparam logic [2:0] OP_ACC1 = 3'd0;
   localparam logic [2:0] OP_ACC2 = 3'd1;
   localparam logic [2:0] OP_ADD  = 3'd2;
   localparam logic [2:0] OP_SUB  = 3'd3;
   localparam logic [2:0] OP_MUL  = 3'd4;
   localparam logic [2:0] OP_DIV  = 3'd5;

   typedef struct packed {
      logic           start;
      logic           clear;
      logic [2:0]     op;
      logic [OPW-1:0] addend;
   } kpc_ctrl_type;

   typedef struct packed {
      logic busy;
      logic second_zero;
   } kpc_stat_type;

endpackage

@@ rtl/kpcalc_req_if.sv @@
interface kpcalc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] key_code;

   modport source (output valid, output key_code, input ready);
   modport sink   (input valid, input key_code, output ready);
endinterface

@@ rtl/kpcalc_rsp_if.sv @@
interface kpcalc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] result_value;
   logic               divide_by_zero;
   logic               unknown_operator;

   modport source (output valid, output result_value, output divide_by_zero,
                   output unknown_operator, input ready);
   modport sink   (input valid, input result_value, input divide_by_zero,
                   input unknown_operator, output ready);
endinterface

@@ rtl/kpcalc_core.sv @@
module kpcalc_core (
   input  logic                         clock,
   input  logic                         reset,
   input  kpcalc_pkg::kpc_ctrl_type     ctrl,
   output kpcalc_pkg::kpc_stat_type     stat,
   output logic [kpcalc_pkg::OPW-1:0]   result
);
   import kpcalc_pkg::*;

   localparam logic [CW-1:0] LAST = CW'(OPW - 1);

   logic [OPW-1:0] first_ff, first_in;
   logic [OPW-1:0] second_ff, second_in;
   logic [OPW-1:0] work_ff, work_in;
   logic [2:0]     hist_ff, hist_in;
   logic [1:0]     carry_ff, carry_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           busy_ff, busy_in;
   logic [2:0]     op_ff, op_in;

   logic [OPW-1:0] tgt;
   logic [2:0]     sum3;
   logic [OPW:0]   shifted;
   logic [OPW:0]   diff;

   always_comb begin
      first_in  = first_ff;
      second_in = second_ff;
      work_in   = work_ff;
      hist_in   = hist_ff;
      carry_in  = carry_ff;
      count_in  = count_ff;
      busy_in   = busy_ff;
      op_in     = op_ff;
      tgt       = (op_ff == OP_ACC1) ? first_ff : second_ff;
      sum3      = '0;
      shifted   = {work_ff, first_ff[OPW-1]};
      diff      = shifted - {1'b0, second_ff};

      if (ctrl.clear) begin
         first_in  = '0;
         second_in = '0;
      end else if (ctrl.start) begin
         busy_in  = 1'b1;
         op_in    = ctrl.op;
         count_in = '0;
         hist_in  = '0;
         carry_in = (ctrl.op == OP_SUB) ? 2'd1 : 2'd0;
         work_in  = (ctrl.op == OP_ACC1 || ctrl.op == OP_ACC2) ? ctrl.addend : '0;
      end else if (busy_ff) begin
         count_in = count_ff + 1'b1;
         if (count_ff == LAST) begin
            busy_in = 1'b0;
         end
         case (op_ff)
            OP_ACC1, OP_ACC2: begin
               // acc*10 bit i = acc[i-1] + acc[i-3], taken from the history
               sum3 = {2'b0, hist_ff[2]} + {2'b0, hist_ff[0]} + {2'b0, work_ff[0]}
                      + {1'b0, carry_ff};
               carry_in = sum3[2:1];
               hist_in  = {hist_ff[1:0], tgt[0]};
               work_in  = {work_ff[OPW-1], work_ff[OPW-1:1]};
               if (op_ff == OP_ACC1) begin
                  first_in  = {sum3[0], first_ff[OPW-1:1]};
               end else begin
                  second_in = {sum3[0], second_ff[OPW-1:1]};
               end
            end
            OP_ADD, OP_SUB: begin
               sum3 = {2'b0, first_ff[0]}
                      + {2'b0, second_ff[0] ^ (op_ff == OP_SUB)}
                      + {2'b0, carry_ff[0]};
               carry_in  = {1'b0, sum3[1]};
               first_in  = {sum3[0], first_ff[OPW-1:1]};
               second_in = {second_ff[0], second_ff[OPW-1:1]};
            end
            OP_MUL: begin
               if (second_ff[0]) begin
                  work_in = work_ff + first_ff;
               end
               first_in  = {first_ff[OPW-2:0], 1'b0};
               second_in = {1'b0, second_ff[OPW-1:1]};
            end
            OP_DIV: begin
               // restoring step: one quotient bit a cycle into first
               if (!diff[OPW]) begin
                  work_in = diff[OPW-1:0];
               end else begin
                  work_in = shifted[OPW-1:0];
               end
               first_in = {first_ff[OPW-2:0], ~diff[OPW]};
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff  <= '0;
         second_ff <= '0;
         busy_ff   <= 1'b0;
         count_ff  <= '0;
         op_ff     <= OP_ACC1;
      end else begin
         first_ff  <= first_in;
         second_ff <= second_in;
         busy_ff   <= busy_in;
         count_ff  <= count_in;
         op_ff     <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff  <= work_in;
      hist_ff  <= hist_in;
      carry_ff <= carry_in;
   end

   assign result           = (op_ff == OP_MUL) ? work_ff : first_ff;
   assign stat.busy        = busy_ff;
   assign stat.second_zero = (second_ff == '0);

endmodule

@@ rtl/keypad_two_operand_calculator_unit.sv @@
// Two-operand keypad calculator. Keys arrive one per transfer on req_chan:
// leading digits build the first operand, the first non-digit key is the
// operator, every later key is folded into the second operand as
// operand*10 + (key - '0'), wrapping at the operand width. Code 0 is
// ignored. '=' yields one transfer on rsp_chan with the sum, difference,
// product or unsigned quotient (low 32 bits) and clears the entry state.
// A missing or unknown operator gives 0 with unknown_operator set; '/'
// with a zero second operand gives 0 with divide_by_zero set.
// Timing: arithmetic runs through a bit-serial unit that takes one bit of
// the operand per cycle. An operand key holds off the next key until the
// serial unit is done; an operator or no-key code does not hold it off. '='
// with valid arithmetic runs the serial unit, then loads the result and
// takes the next key after the load; when it ends in a flag the serial unit
// is skipped, the result is loaded directly and the next key is taken after
// the load. The result register frees the input side while a
// result waits; only a second '=' stalls behind it.
module keypad_two_operand_calculator_unit (
   input  logic          clock,
   input  logic          reset,
   kpcalc_req_if.sink    req_chan,
   kpcalc_rsp_if.source  rsp_chan
);
   import kpcalc_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CALC = 2'd1;
   localparam logic [1:0] ST_LOAD = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic                seen_ff, seen_in;     // operator captured
   logic [7:0]          opkey_ff, opkey_in;
   logic                eq_ff, eq_in;         // current job ends in a result
   logic                dz_ff, dz_in;
   logic                unk_ff, unk_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [31:0]         result_ff, result_in;
   logic                rdz_ff, rdz_in;
   logic                runk_ff, runk_in;

   kpc_ctrl_type        ctrl;
   kpc_stat_type        stat;
   logic [OPW-1:0]      core_result;

   logic                accept;
   logic [8:0]          digit9;
   logic                known_op;
   logic [2:0]          eq_op;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   // key - '0' as a signed 9-bit value, then sign-extended to the operand
   assign digit9         = {1'b0, req_chan.key_code} - {1'b0, KEY_ZERO};

   always_comb begin
      known_op = seen_ff;
      eq_op    = OP_ADD;
      case (opkey_ff)
         KEY_PLUS:  eq_op = OP_ADD;
         KEY_MINUS: eq_op = OP_SUB;
         KEY_TIMES: eq_op = OP_MUL;
         KEY_DIV:   eq_op = OP_DIV;
         default:   known_op = 1'b0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      seen_in      = seen_ff;
      opkey_in     = opkey_ff;
      eq_in        = eq_ff;
      dz_in        = dz_ff;
      unk_in       = unk_ff;
      rsp_valid_in = rsp_valid_ff;
      result_in    = result_ff;
      rdz_in       = rdz_ff;
      runk_in      = runk_ff;
      ctrl.start   = 1'b0;
      ctrl.clear   = 1'b0;
      ctrl.op      = OP_ACC1;
      ctrl.addend  = OPW'($signed(digit9));

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept && req_chan.key_code != KEY_NONE) begin
               if (req_chan.key_code != KEY_EQ) begin
                  eq_in = 1'b0;
                  if (seen_ff) begin
                     ctrl.start = 1'b1;
                     ctrl.op    = OP_ACC2;
                     state_in   = ST_CALC;
                  end else if (req_chan.key_code inside {[KEY_ZERO:KEY_NINE]}) begin
                     ctrl.start = 1'b1;
                     ctrl.op    = OP_ACC1;
                     state_in   = ST_CALC;
                  end else begin
                     opkey_in = req_chan.key_code;
                     seen_in  = 1'b1;
                  end
               end else begin
                  eq_in = 1'b1;
                  if (!known_op) begin
                     unk_in   = 1'b1;
                     dz_in    = 1'b0;
                     state_in = ST_LOAD;
                  end else if (eq_op == OP_DIV && stat.second_zero) begin
                     unk_in   = 1'b0;
                     dz_in    = 1'b1;
                     state_in = ST_LOAD;
                  end else begin
                     unk_in     = 1'b0;
                     dz_in      = 1'b0;
                     ctrl.start = 1'b1;
                     ctrl.op    = eq_op;
                     state_in   = ST_CALC;
                  end
               end
            end
         end
         ST_CALC: begin
            if (!stat.busy) begin
               state_in = eq_ff ? ST_LOAD : ST_IDLE;
            end
         end
         ST_LOAD: begin
            // wait for the output register to be free, then clear the entry
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               result_in    = (dz_ff || unk_ff) ? '0 : RESULT_W'(core_result);
               rdz_in       = dz_ff;
               runk_in      = unk_ff;
               ctrl.clear   = 1'b1;
               seen_in      = 1'b0;
               opkey_in     = KEY_NONE;
               eq_in        = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seen_ff      <= 1'b0;
         opkey_ff     <= KEY_NONE;
         eq_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         opkey_ff     <= opkey_in;
         eq_ff        <= eq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dz_ff     <= dz_in;
      unk_ff    <= unk_in;
      result_ff <= result_in;
      rdz_ff    <= rdz_in;
      runk_ff   <= runk_in;
   end

   kpcalc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .stat   (stat),
      .result (core_result)
   );

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.result_value     = result_ff;
   assign rsp_chan.divide_by_zero   = rdz_ff;
   assign rsp_chan.unknown_operator = runk_ff;

   // both flags never raised together
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rdz_ff && runk_ff))
      else $error("both error flags set");

   // a flagged result carries zero
   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rdz_ff || runk_ff) |-> result_ff == '0)
      else $error("flagged result not zero");

   // an operand key starts the serial unit
   a_digit_starts: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.key_code != KEY_NONE && req_chan.key_code != KEY_EQ
      && (seen_ff || (req_chan.key_code >= KEY_ZERO && req_chan.key_code <= KEY_NINE))
      |=> stat.busy)
      else $error("operand key did not start the serial unit");

   // the serial unit is never busy while keys are taken
   a_idle_not_busy: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !stat.busy)
      else $error("key taken while serial unit busy");

   // loading a result clears the operator
   a_load_clears: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD && (!rsp_valid_ff || rsp_chan.ready) |=> !seen_ff && rsp_valid_ff)
      else $error("entry state not cleared on result");

endmodule

@@ test/keypad_two_operand_calculator_unit_test.sv @@
// Keypad calculator: keys are replayed from a queue by a bursty driver,
// results are taken by a receiver that stalls on a rotating pattern. The
// monitor folds every accepted key into its own copy of the entry state,
// and on '=' it queues the expected result. Each result transfer is then
// checked, field by field, against the oldest queued one.
module keypad_two_operand_calculator_unit_test;
   import kpcalc_pkg::*;

   localparam int          CYCLE_LIMIT = 400000;
   localparam int          KEY_TARGET  = 1900;
   localparam logic [7:0]  KEY_PERCENT = 8'h25;   // not an operator: unknown_operator

   typedef struct packed {
      logic signed [RESULT_W-1:0] value;
      logic                       div_zero;
      logic                       unknown_op;
   } calc_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   kpcalc_req_if req_if();
   kpcalc_rsp_if rsp_if();

   keypad_two_operand_calculator_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Predictor: own copy of the entry state
   // ---------------------------------------------------------------
   logic [OPW-1:0] first_operand  = '0;
   logic [OPW-1:0] second_operand = '0;
   logic [7:0]     operator_code  = KEY_NONE;
   logic           operator_held  = 1'b0;

   calc_result_type result_queue [$];   // results still owed by the block
   logic [7:0]      key_queue [$];      // keys waiting for the driver
   int              keys_total    = 0;
   int              keys_accepted = 0;
   int              mismatch_count = 0;

   // operand*10 + (key - '0'), wrapping at the operand width
   function automatic logic [OPW-1:0] shift_in_key(logic [OPW-1:0] acc, logic [7:0] key);
      logic [OPW-1:0] next;
      next = acc * OPW'(10) + OPW'(key) - OPW'(KEY_ZERO);
      return next;
   endfunction

   // Folds one accepted key into the state; returns 1 when '=' gives a result
   function automatic bit calc_key(input logic [7:0] key, output calc_result_type res);
      logic [OPW-1:0] wide;
      wide = '0;
      res  = '0;
      if (key == KEY_NONE)
         return 1'b0;
      if (key != KEY_EQ) begin
         if (operator_held)
            second_operand = shift_in_key(second_operand, key);
         else if (key >= KEY_ZERO && key <= KEY_NINE)
            first_operand = shift_in_key(first_operand, key);
         else begin
            operator_code = key;
            operator_held = 1'b1;
         end
         return 1'b0;
      end
      if (!operator_held)
         res.unknown_op = 1'b1;
      else if (operator_code == KEY_PLUS)
         wide = first_operand + second_operand;
      else if (operator_code == KEY_MINUS)
         wide = first_operand - second_operand;
      else if (operator_code == KEY_TIMES)
         wide = first_operand * second_operand;
      else if (operator_code == KEY_DIV) begin
         if (second_operand == '0)
            res.div_zero = 1'b1;
         else
            wide = first_operand / second_operand;
      end else
         res.unknown_op = 1'b1;
      res.value = RESULT_W'(wide);
      // '=' always leaves the entry state clear
      first_operand  = '0;
      second_operand = '0;
      operator_code  = KEY_NONE;
      operator_held  = 1'b0;
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------
   // Driver: bursts of transfers with random gaps between them
   // ---------------------------------------------------------------
   int burst_left = 1;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid    <= 1'b0;
         req_if.key_code <= KEY_NONE;
         burst_left      <= $urandom_range(1, 20);
         gap_left        <= 0;
      end else if (!req_if.valid || req_if.ready) begin
         // slot free: either idle or the last key has just been transferred
         if (gap_left != 0) begin
            gap_left     <= gap_left - 1;
            req_if.valid <= 1'b0;
         end else if (key_queue.size() != 0) begin
            req_if.valid    <= 1'b1;
            req_if.key_code <= key_queue.pop_front();
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 20);
               // a quarter of bursts run straight on with no gap at all
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // Receiver: ready follows a rotating 16-bit pattern, swapped whenever
   // the 6-bit age counter wraps; bit 0 is forced so no stall outlasts the pattern
   // ---------------------------------------------------------------
   logic [15:0] stall_pattern = 16'hFFFF;
   logic [5:0]  pattern_age   = '0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= stall_pattern[0];
         pattern_age  <= pattern_age + 1'b1;
         if (pattern_age == '1)
            stall_pattern <= ($urandom_range(0, 2) == 0) ? 16'hFFFF
                                                         : (16'($urandom) | 16'h0001);
         else
            stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
      end
   end

   // ---------------------------------------------------------------
   // Monitor: predicts on key transfers, checks on result transfers
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      calc_result_type predicted;
      calc_result_type owed;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            if (calc_key(req_if.key_code, predicted))
               result_queue.push_back(predicted);
            keys_accepted++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (result_queue.size() == 0) begin
               $error("result transfer with no result owed: value %0d",
                      rsp_if.result_value);
               mismatch_count++;
            end else begin
               owed = result_queue.pop_front();
               if (rsp_if.result_value !== owed.value) begin
                  $error("result_value: expected %0d, got %0d",
                         owed.value, rsp_if.result_value);
                  mismatch_count++;
               end
               if (rsp_if.divide_by_zero !== owed.div_zero) begin
                  $error("divide_by_zero: expected %0b, got %0b",
                         owed.div_zero, rsp_if.divide_by_zero);
                  mismatch_count++;
               end
               if (rsp_if.unknown_operator !== owed.unknown_op) begin
                  $error("unknown_operator: expected %0b, got %0b",
                         owed.unknown_op, rsp_if.unknown_operator);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   task automatic push_key(input logic [7:0] key);
      key_queue.push_back(key);
      keys_total++;
   endtask

   function automatic logic [7:0] random_digit();
      return KEY_ZERO + 8'($urandom_range(0, 9));
   endfunction

   // anything but no-key and '=', so a sequence is not cut short
   function automatic logic [7:0] random_stray_key();
      logic [7:0] key;
      key = 8'($urandom_range(1, 255));
      while (key == KEY_EQ)
         key = 8'($urandom_range(1, 255));
      return key;
   endfunction

   // mostly short operands, now and then long ones that wrap
   function automatic int operand_length();
      return ($urandom_range(0, 7) == 0) ? $urandom_range(5, 14) : $urandom_range(0, 4);
   endfunction

   task automatic queue_sequence();
      int         digits;
      logic [7:0] op_key;
      if ($urandom_range(0, 9) == 0) begin
         // noise: raw codes over the full range, '=' and no-key included
         repeat ($urandom_range(1, 6))
            push_key(8'($urandom_range(0, 255)));
         return;
      end
      digits = operand_length();
      repeat (digits) begin
         if ($urandom_range(0, 11) == 0)
            push_key(KEY_NONE);
         push_key(random_digit());
      end
      case ($urandom_range(0, 9))
         0, 1:    op_key = KEY_PLUS;
         2, 3:    op_key = KEY_MINUS;
         4, 5:    op_key = KEY_TIMES;
         6, 7:    op_key = KEY_DIV;
         8: begin
            op_key = random_stray_key();
            while (op_key >= KEY_ZERO && op_key <= KEY_NINE)
               op_key = random_stray_key();
         end
         default: op_key = KEY_NONE;   // '=' with no operator
      endcase
      if (op_key != KEY_NONE) begin
         push_key(op_key);
         digits = operand_length();
         repeat (digits) begin
            if ($urandom_range(0, 11) == 0)
               push_key(KEY_NONE);
            // non-digits after the operator still fold into the second operand
            push_key(($urandom_range(0, 9) == 0) ? random_stray_key() : random_digit());
         end
      end
      push_key(KEY_EQ);
   endtask

   initial begin
      logic [7:0] opening_keys [$];

      // directed: no key, '=' alone, each operator, negative difference,
      // divide by zero, stray code after the operator, unknown operator
      opening_keys = '{KEY_NONE, KEY_EQ,
                       "1", "2", KEY_PLUS, "3", KEY_EQ,
                       "7", KEY_MINUS, "5", "0", KEY_EQ,
                       "6", KEY_TIMES, "7", KEY_EQ,
                       "9", KEY_DIV, "0", KEY_EQ,
                       KEY_DIV, 8'hFF, KEY_EQ,
                       KEY_PERCENT, KEY_EQ};
      foreach (opening_keys[i])
         push_key(opening_keys[i]);
      while (keys_total < KEY_TARGET)
         queue_sequence();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (keys_accepted != keys_total)
         @(posedge clock);
      while (result_queue.size() != 0)
         @(posedge clock);
      // room for a stray result behind the last key
      repeat (3 * OPW) @(posedge clock);

      if (mismatch_count == 0)
         $display("keypad_two_operand_calculator_unit_test: clean");
      else
         $display("keypad_two_operand_calculator_unit_test: errors");
      $finish;
   end

   // watchdog
   int cycle_count = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("keypad_two_operand_calculator_unit_test: errors");
         $finish;
      end
   end

endmodule

@@ keypad_two_operand_calculator_unit.f @@
rtl/kpcalc_pkg.sv
rtl/kpcalc_req_if.sv
rtl/kpcalc_rsp_if.sv
rtl/kpcalc_core.sv
rtl/keypad_two_operand_calculator_unit.sv
test/keypad_two_operand_calculator_unit_test.sv
